// File: design/u2u_pkg.sv
// Shared types for the UTF-8 to UTF-16 stream decoder.
// Holds the front-to-back request record, the code unit record and the
// back end phase encoding. No dependencies.
package u2u_pkg;

    // Width of the folded code point accumulator
    localparam int unsigned ACC_W = 31;

    // One request from the front end: an optional closed character (may
    // need a surrogate pair) followed by an optional single-unit character
    typedef struct packed {
        logic             a_valid;
        logic [ACC_W-1:0] a_value;
        logic [2:0]       a_count;
        logic             b_valid;
        logic [6:0]       b_value;
    } group_t;

    // One UTF-16 code unit as seen on the result side
    typedef struct packed {
        logic [15:0] code_unit;
        logic [2:0]  byte_count;
        logic        last_unit;
    } unit_t;

    // Back end position inside the request at the head of the queue
    typedef enum logic [1:0] {
        PH_START,
        PH_A_LOW,
        PH_B
    } phase_t;

endpackage

// File: design/u2u_fifo.sv
// Small first-in first-out queue of registers with a combinational head.
// Used between front and back and on the result side. No package needed.
module u2u_fifo #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: design/u2u_front.sv
// Front end: classifies each byte, folds continuations and emits requests.
// Depends on u2u_pkg for the request record.
module u2u_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            doc_end,
    output logic            req_push,
    output u2u_pkg::group_t req
);
    import u2u_pkg::*;

    // Count consecutive ones from bit 5 downward
    function automatic logic [2:0] lead_run(input logic [7:0] b);
        logic [2:0] run;
        logic       stop;
        run  = '0;
        stop = 1'b0;
        for (int i = 5; i >= 0; i--)
        begin
            if (!stop && b[i])
            begin
                run = run + 3'd1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        return run;
    endfunction

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]       pending_reg, pending_next;
    logic [2:0]       taken_reg, taken_next;

    logic             is_cont;
    logic             open_char;
    logic [2:0]       run;
    logic             long_lead;
    logic [7:0]       lead_mask;
    logic [4:0]       payload;
    logic [ACC_W-1:0] acc_fold;
    logic [2:0]       taken_inc;

    assign is_cont   = (in_byte[7:6] == 2'b10);
    assign open_char = (pending_reg != 3'd0);
    assign run       = lead_run(in_byte);
    assign long_lead = (run >= 3'd5);
    assign lead_mask = 8'h3F >> (run + 3'd1);
    assign payload   = long_lead ? 5'd0 : 5'(in_byte & lead_mask);
    assign acc_fold  = {acc_reg[ACC_W-7:0], in_byte[5:0]};
    assign taken_inc = taken_reg + 3'd1;

    // Decode the byte against the open character
    always_comb
    begin
        acc_next     = acc_reg;
        pending_next = pending_reg;
        taken_next   = taken_reg;
        req          = '0;
        if (accept)
        begin
            if (open_char && is_cont)
            begin
                // Fold six bits; close when complete or at document end
                acc_next     = acc_fold;
                taken_next   = taken_inc;
                pending_next = pending_reg - 3'd1;
                if (pending_reg == 3'd1 || doc_end)
                begin
                    req.a_valid  = 1'b1;
                    req.a_value  = acc_fold;
                    req.a_count  = taken_inc;
                    acc_next     = '0;
                    pending_next = '0;
                    taken_next   = '0;
                end
            end
            else
            begin
                // Close any open character early
                req.a_valid  = open_char;
                req.a_value  = acc_reg;
                req.a_count  = taken_reg;
                acc_next     = '0;
                pending_next = '0;
                taken_next   = '0;
                if (!in_byte[7])
                begin
                    req.b_valid = 1'b1;
                    req.b_value = in_byte[6:0];
                end
                else if (doc_end)
                begin
                    req.b_valid = 1'b1;
                    req.b_value = 7'(payload);
                end
                else
                begin
                    acc_next     = ACC_W'(payload);
                    taken_next   = 3'd1;
                    pending_next = long_lead ? 3'd6 : run + 3'd1;
                end
            end
        end
    end

    assign req_push = req.a_valid || req.b_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pending_reg <= '0;
            taken_reg   <= '0;
        end
        else
        begin
            acc_reg     <= acc_next;
            pending_reg <= pending_next;
            taken_reg   <= taken_next;
        end
    end

endmodule

// File: design/u2u_back.sv
// Back end: expands each request into UTF-16 code units, one per cycle
// while unit_full is low. Uses u2u_pkg request, unit and phase types.
module u2u_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_empty,
    input  u2u_pkg::group_t req,
    output logic            req_pop,
    input  logic            unit_full,
    output logic            unit_push,
    output u2u_pkg::unit_t  unit
);
    import u2u_pkg::*;

    localparam logic [15:0] HIGH_BASE  = 16'hD800;
    localparam logic [15:0] LOW_BASE   = 16'hDC00;
    localparam logic [15:0] PLANE_HIGH = 16'h0040;

    phase_t      phase_reg, phase_next;
    logic        emit;
    logic        pair;
    logic        done;
    logic [15:0] high_unit;
    logic [15:0] low_unit;

    assign emit      = !req_empty && !unit_full;
    assign pair      = |req.a_value[ACC_W-1:16];
    assign high_unit = HIGH_BASE + (req.a_value[25:10] - PLANE_HIGH);
    assign low_unit  = LOW_BASE + {6'd0, req.a_value[9:0]};

    // Advance through the units of the head request
    always_comb
    begin
        phase_next = phase_reg;
        if (emit)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (req.a_valid && pair)
                    begin
                        phase_next = PH_A_LOW;
                    end
                    else if (req.a_valid && req.b_valid)
                    begin
                        phase_next = PH_B;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_A_LOW:
                begin
                    phase_next = req.b_valid ? PH_B : PH_START;
                end
                PH_B:
                begin
                    phase_next = PH_START;
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    // Select the unit for the current phase
    always_comb
    begin
        unit.code_unit  = {9'd0, req.b_value};
        unit.byte_count = 3'd1;
        unit.last_unit  = 1'b1;
        done            = 1'b1;
        case (phase_reg)
            PH_START:
            begin
                if (req.a_valid)
                begin
                    unit.byte_count = req.a_count;
                    if (pair)
                    begin
                        unit.code_unit = high_unit;
                        unit.last_unit = 1'b0;
                        done           = 1'b0;
                    end
                    else
                    begin
                        unit.code_unit = req.a_value[15:0];
                        done           = !req.b_valid;
                    end
                end
            end
            PH_A_LOW:
            begin
                unit.code_unit  = low_unit;
                unit.byte_count = req.a_count;
                done            = !req.b_valid;
            end
            PH_B:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    assign unit_push = emit;
    assign req_pop   = emit && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: design/utf8_to_utf16_stream_decoder_top.sv
// UTF-8 to UTF-16 stream decoder, top level.
// Throughput: one byte per cycle while the request queue is not full; the back end
// emits one code unit per cycle while the result queue has room, so a byte yielding
// up to three units holds the byte side once queues fill. Each request is queued,
// then its units are registered in the result queue and can be popped once shown.
// Reset: rst_n clears the open character and empties both queues.
module utf8_to_utf16_stream_decoder_top #(
    parameter int unsigned GROUP_DEPTH = 4,
    parameter int unsigned OUT_DEPTH   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        doc_end,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] code_unit,
    output logic [2:0]  byte_count,
    output logic        last_unit
);
    import u2u_pkg::*;

    logic   accept;
    logic   req_push;
    group_t req_in;
    group_t req_head;
    logic   req_empty;
    logic   req_pop;
    logic   unit_full;
    logic   unit_push;
    unit_t  unit_in;
    unit_t  unit_head;

    assign accept = push && !full;

    u2u_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .doc_end  (doc_end),
        .req_push (req_push),
        .req      (req_in)
    );

    // Hold requests between front and back
    u2u_fifo #(
        .DEPTH (GROUP_DEPTH),
        .WIDTH ($bits(group_t))
    ) u_req_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (req_push),
        .wr_data (req_in),
        .rd_en   (req_pop),
        .rd_data (req_head),
        .full    (full),
        .empty   (req_empty)
    );

    u2u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_empty (req_empty),
        .req       (req_head),
        .req_pop   (req_pop),
        .unit_full (unit_full),
        .unit_push (unit_push),
        .unit      (unit_in)
    );

    // Hold finished code units for the consumer
    u2u_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(unit_t))
    ) u_unit_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (unit_push),
        .wr_data (unit_in),
        .rd_en   (pop),
        .rd_data (unit_head),
        .full    (unit_full),
        .empty   (empty)
    );

    assign code_unit  = unit_head.code_unit;
    assign byte_count = unit_head.byte_count;
    assign last_unit  = unit_head.last_unit;

endmodule

// File: test/tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
// Drives document bytes through the push/full side, predicts the code units in
// step with each accepted request, and checks them on the pop side. Uses u2u_pkg.
module tb;

    import u2u_pkg::*;

    // One queued request for the byte side, or a marker that makes it wait
    // until all predicted units have been popped
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       drain;
    } byte_req_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  in_byte = 8'h00;
    logic        doc_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] code_unit;
    logic [2:0]  byte_count;
    logic        last_unit;

    byte_req_t byte_queue[$];
    unit_t     expected_units[$];
    int        errors = 0;

    // Decoder state mirrored by the predictor
    logic [30:0] open_cp = '0;
    logic [2:0]  cont_left = '0;
    logic [2:0]  taken_bytes = '0;

    // Handshake flags, set at the rising edge and consumed at the falling edge
    bit byte_taken = 1'b0;
    bit unit_taken = 1'b0;
    int push_gap = 0;
    int pop_stall = 0;
    int push_quiet = 0;
    int pop_quiet = 0;

    utf8_to_utf16_stream_decoder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .doc_end    (doc_end),
        .empty      (empty),
        .pop        (pop),
        .code_unit  (code_unit),
        .byte_count (byte_count),
        .last_unit  (last_unit)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Queue the units of one closed character, splitting it into a surrogate
    // pair when it lies above the basic plane
    function automatic void emit_char(logic [30:0] cp, logic [2:0] count);
        logic [30:0] v;
        unit_t       u;
        u.byte_count = count;
        if (cp >= 31'h10000)
        begin
            v = cp - 31'h10000;
            u.code_unit = 16'hD800 + v[25:10];
            u.last_unit = 1'b0;
            expected_units.push_back(u);
            u.code_unit = 16'hDC00 + {6'd0, v[9:0]};
            u.last_unit = 1'b1;
            expected_units.push_back(u);
        end
        else
        begin
            u.code_unit = cp[15:0];
            u.last_unit = 1'b1;
            expected_units.push_back(u);
        end
    endfunction

    // Send the open character and clear it
    function automatic void close_char();
        emit_char(open_cp, taken_bytes);
        open_cp = '0;
        cont_left = '0;
        taken_bytes = '0;
    endfunction

    // Advance the decoder by one document byte
    function automatic void decode_byte(logic [7:0] c, logic last);
        int         len;
        logic [7:0] payload;
        if (cont_left != 3'd0)
        begin
            if (c[7:6] == 2'b10)
            begin
                open_cp = {open_cp[24:0], c[5:0]};
                taken_bytes++;
                cont_left--;
                if (cont_left == 3'd0 || last)
                    close_char();
                return;
            end
            // Non-continuation cuts the open character short
            close_char();
        end
        if (!c[7])
        begin
            emit_char({23'd0, c}, 3'd1);
            return;
        end
        // Count ones from bit 5 down; the payload mask narrows with the length
        len = 2;
        for (int b = 5; b >= 0 && c[b]; b--)
            len++;
        if (len >= 7)
        begin
            len = 7;
            payload = 8'h00;
        end
        else
            payload = c & (8'h7F >> len);
        open_cp = {23'd0, payload};
        taken_bytes = 3'd1;
        cont_left = 3'(len - 1);
        if (last)
            close_char();
    endfunction

    // Idle length: mostly none or short, a few long, with quiet stretches
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_byte(logic [7:0] value, logic last);
        byte_req_t r;
        r.value = value;
        r.last = last;
        r.drain = 1'b0;
        byte_queue.push_back(r);
    endfunction

    function automatic void queue_drain();
        byte_req_t r;
        r = '0;
        r.drain = 1'b1;
        byte_queue.push_back(r);
    endfunction

    // Fill the request queue: directed cases first, then random characters
    function automatic void build_stimulus();
        int         sent;
        int         r;
        int         len;
        int         cut;
        logic [7:0] lead;
        // ASCII extremes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // Four-byte character, sent as a surrogate pair
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h80, 1'b0);
        // Five-byte lead cut short by ASCII above the basic plane
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'h41, 1'b0);
        // Lead cut short by a lead that document end then closes
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hE2, 1'b1);
        // Document end in the middle of a character
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);
        // Stray continuation taken as a lead
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h41, 1'b0);
        // Longest lead with six continuations overflows the accumulator
        queue_byte(8'hFF, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_byte(8'hBF, 1'b0);
        // Long lead closed at once by document end
        queue_byte(8'hFE, 1'b1);
        queue_drain();

        // Mostly well-formed characters, some cut short, some noise
        sent = 0;
        while (sent < 450)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                sent++;
            end
            else
            begin
                if (r < 35)
                    len = 1;
                else if (r < 55)
                    len = 2;
                else if (r < 75)
                    len = 3;
                else if (r < 90)
                    len = 4;
                else
                    len = $urandom_range(5, 7);
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
                if (len == 1)
                    lead = 8'($urandom_range(0, 127));
                else if (len == 7)
                    lead = $urandom_range(0, 1) ? 8'hFF : 8'hFE;
                else
                    lead = 8'((8'hFF << (8 - len)) | ($urandom & (8'h7F >> len)));
                for (int i = 0; i < cut; i++)
                begin
                    queue_byte((i == 0) ? lead : 8'(8'h80 | $urandom_range(0, 63)),
                               (i == cut - 1) ? ($urandom_range(0, 19) == 0)
                                              : ($urandom_range(0, 63) == 0));
                    sent++;
                end
            end
            if ($urandom_range(0, 99) == 0)
                queue_drain();
        end
    endfunction

    // Check popped units and predict on accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                unit_taken = 1'b1;
                if (expected_units.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected unit %h count %0d last %b", $time,
                             code_unit, byte_count, last_unit);
                end
                else
                begin
                    if (code_unit !== expected_units[0].code_unit)
                    begin
                        errors++;
                        $display("%0t: code_unit expected %h got %h", $time,
                                 expected_units[0].code_unit, code_unit);
                    end
                    if (byte_count !== expected_units[0].byte_count)
                    begin
                        errors++;
                        $display("%0t: byte_count expected %0d got %0d", $time,
                                 expected_units[0].byte_count, byte_count);
                    end
                    if (last_unit !== expected_units[0].last_unit)
                    begin
                        errors++;
                        $display("%0t: last_unit expected %b got %b", $time,
                                 expected_units[0].last_unit, last_unit);
                    end
                    void'(expected_units.pop_front());
                end
            end
            if (push && !full)
            begin
                byte_taken = 1'b1;
                decode_byte(in_byte, doc_end);
            end
        end
    end

    // Byte side: present queued requests with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_taken)
            begin
                byte_taken = 1'b0;
                void'(byte_queue.pop_front());
                push_gap = pick_gap(push_quiet);
            end
            if (push_gap > 0)
            begin
                push_gap--;
                push <= 1'b0;
            end
            else if (byte_queue.size() == 0)
                push <= 1'b0;
            else if (byte_queue[0].drain)
            begin
                // Hold off until every predicted unit has been popped
                if (expected_units.size() == 0)
                    void'(byte_queue.pop_front());
                push <= 1'b0;
            end
            else
            begin
                push <= 1'b1;
                in_byte <= byte_queue[0].value;
                doc_end <= byte_queue[0].last;
            end
        end
    end

    // Result side: stall pop at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (unit_taken)
            begin
                unit_taken = 1'b0;
                pop_stall = pick_gap(pop_quiet);
            end
            if (pop_stall > 0)
            begin
                pop_stall--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Reset, run, drain and report
    initial
    begin
        build_stimulus();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (byte_queue.size() != 0 || expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (!empty)
        begin
            errors++;
            $display("%0t: unit %h left waiting with nothing expected", $time, code_unit);
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
design/u2u_pkg.sv
design/u2u_fifo.sv
design/u2u_front.sv
design/u2u_back.sv
design/utf8_to_utf16_stream_decoder_top.sv
test/tb.sv
